// ----- design/dawu_pkg.sv -----
// types, constants and calendar tables shared by the date adder
`default_nettype none
package dawu_pkg;

  // internal year and day-count width, covers start year plus a 16-bit amount
  localparam int YEAR_W  = 17;
  localparam int DVS_W   = 9;
  localparam int SUM_W   = 12;
  localparam int Y100_W  = 7;
  localparam int Y400_W  = 9;
  localparam int J_W     = 10;

  // reciprocal scale: every dividend is below 2**RCP_SH, so the estimate is at most one short
  localparam int RCP_SH  = YEAR_W;
  localparam int RCP_W   = 15;

  localparam logic [3:0] M_JAN = 4'd0;
  localparam logic [3:0] M_FEB = 4'd1;
  localparam logic [3:0] M_DEC = 4'd11;
  localparam logic [4:0] DEC_DAYS = 5'd31;

  localparam logic [DVS_W-1:0] DIV_12  = DVS_W'(12);
  localparam logic [DVS_W-1:0] DIV_100 = DVS_W'(100);
  localparam logic [DVS_W-1:0] DIV_400 = DVS_W'(400);
  localparam logic [DVS_W-1:0] DIV_7   = DVS_W'(7);

  localparam logic [RCP_W-1:0] RCP_12  = RCP_W'((2 ** RCP_SH) / 12);
  localparam logic [RCP_W-1:0] RCP_100 = RCP_W'((2 ** RCP_SH) / 100);
  localparam logic [RCP_W-1:0] RCP_400 = RCP_W'((2 ** RCP_SH) / 400);
  localparam logic [RCP_W-1:0] RCP_7   = RCP_W'((2 ** RCP_SH) / 7);

  localparam logic [1:0] OP_ADD_DAYS   = 2'd0;
  localparam logic [1:0] OP_ADD_MONTHS = 2'd1;
  localparam logic [1:0] OP_ADD_YEARS  = 2'd2;
  localparam logic [1:0] OP_NONE       = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_M12,
    S_YCHK,
    S_M100,
    S_M400,
    S_WALK,
    S_CLAMP,
    S_SAT,
    S_ZDIV,
    S_ZSUM,
    S_WDIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_FIX
  } div_phase_t;

  typedef struct packed {
    logic              start;
    logic [YEAR_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [YEAR_W-1:0] quo;
    logic [DVS_W-1:0]  rem;
  } div_rsp_t;

  // days in month m (0 is January)
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // zeller month term floor(13*(mm+1)/5), january and february as months 13 and 14
  function automatic logic [5:0] month_off(input logic [3:0] m);
    logic [5:0] off;
    unique case (m)
      4'd0:    off = 6'd36;
      4'd1:    off = 6'd39;
      4'd2:    off = 6'd10;
      4'd3:    off = 6'd13;
      4'd4:    off = 6'd15;
      4'd5:    off = 6'd18;
      4'd6:    off = 6'd20;
      4'd7:    off = 6'd23;
      4'd8:    off = 6'd26;
      4'd9:    off = 6'd28;
      4'd10:   off = 6'd31;
      default: off = 6'd33;
    endcase
    return off;
  endfunction

  // scaled reciprocal of one of the fixed divisors
  function automatic logic [RCP_W-1:0] recip(input logic [DVS_W-1:0] dvs);
    logic [RCP_W-1:0] r;
    unique case (dvs)
      DIV_12:  r = RCP_12;
      DIV_100: r = RCP_100;
      DIV_400: r = RCP_400;
      default: r = RCP_7;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/dawu_div.sv -----
// shared constant divider: reciprocal multiply, then one correction step
`default_nettype none
module dawu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  dawu_pkg::div_req_t req,
  output dawu_pkg::div_rsp_t rsp
);
  import dawu_pkg::*;

  localparam int PROD_W = YEAR_W + RCP_W;
  localparam int BACK_W = YEAR_W + DVS_W;

  div_phase_t        phase_r, phase_nxt;
  logic              done_r, done_nxt;
  logic [YEAR_W-1:0] x_r, x_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [RCP_W-1:0]  rcp_r, rcp_nxt;
  logic [YEAR_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;

  logic [PROD_W-1:0] prod;
  logic [BACK_W-1:0] back;
  logic [YEAR_W-1:0] dvs_ext;
  logic [YEAR_W-1:0] r_est;
  logic              ge;

  assign prod    = {{YEAR_W{1'b0}}, rcp_r} * {{RCP_W{1'b0}}, x_r};
  assign back    = {{YEAR_W{1'b0}}, dvs_r} * {{DVS_W{1'b0}}, q_r};
  assign dvs_ext = YEAR_W'(dvs_r);
  assign r_est   = x_r - back[YEAR_W-1:0];
  assign ge      = (r_est >= dvs_ext);

  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    x_nxt     = x_r;
    dvs_nxt   = dvs_r;
    rcp_nxt   = rcp_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    unique case (phase_r)
      DV_IDLE: begin
        if (req.start) begin
          x_nxt     = req.dividend;
          dvs_nxt   = req.divisor;
          rcp_nxt   = recip(req.divisor);
          phase_nxt = DV_MUL;
        end
      end
      DV_MUL: begin
        // estimate is the quotient or one below it
        q_nxt     = YEAR_W'(prod[PROD_W-1:RCP_SH]);
        phase_nxt = DV_FIX;
      end
      DV_FIX: begin
        q_nxt     = ge ? q_r + 1'b1 : q_r;
        rem_nxt   = ge ? DVS_W'(r_est - dvs_ext) : DVS_W'(r_est);
        done_nxt  = 1'b1;
        phase_nxt = DV_IDLE;
      end
      default: phase_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    dvs_r <= dvs_nxt;
    rcp_r <= rcp_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ----- design/date_add_and_weekday_unit.sv -----
// date adder with weekday: sequencer, month walker and output register
//
//   channel | dir | tdata (low bit up)                              | tuser
//   in_     | in  | in_day 5, in_month 4, in_year 14, amount 16, pad | op 2
//   out_    | out | out_day 5, out_month 4, out_year 14, weekday 3   | overflow 1
//
// the result follows the input transfer once the sequencer is through: add months first
// carries the month sum through the divider, add days walks one month per step, and a
// start year past the maximum skips to saturation. the month walk and the shared
// constant divider (year mod 100/400, month carry, zeller terms, mod 7) set the timing.
// rst_n is synchronous, active low, and clears the sequencer and valid flags.
// a finished result waits in the output register while the next item is taken.
`default_nettype none
module date_add_and_weekday_unit #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // in_day, in_month, in_year, amount, zero pad
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_day, out_month, out_year, weekday, zero pad
  output logic [0:0]  out_tuser   // overflow
);
  import dawu_pkg::*;

  localparam logic [YEAR_W-1:0] MAX_Y = YEAR_W'(MAX_YEAR);

  state_t            state_r, state_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [YEAR_W-1:0] d_r, d_nxt;
  logic [3:0]        m_r, m_nxt;
  logic [YEAR_W-1:0] y_r, y_nxt;
  logic [15:0]       amt_r, amt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [Y100_W-1:0] y100_r, y100_nxt;
  logic [Y400_W-1:0] y400_r, y400_nxt;
  logic [Y100_W-1:0] k_r, k_nxt;
  logic [J_W-1:0]    j_r, j_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [2:0]        wd_r, wd_nxt;
  logic              pend_r, pend_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [4:0]        od_r, od_nxt;
  logic [3:0]        om_r, om_nxt;
  logic [13:0]       oy_r, oy_nxt;
  logic [2:0]        owd_r, owd_nxt;
  logic              oovf_r, oovf_nxt;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              div_state;

  logic [4:0]        in_day_f;
  logic [3:0]        in_month_f;
  logic [13:0]       in_year_f;
  logic              leap;
  logic [4:0]        len;
  logic [YEAR_W-1:0] y_inc;
  logic [YEAR_W-1:0] zy;
  logic [2:0]        h;

  assign in_day_f   = in_tdata[4:0];
  assign in_month_f = in_tdata[8:5];
  assign in_year_f  = in_tdata[22:9];

  assign leap  = ((y_r[1:0] == 2'd0) && (y100_r != '0)) || (y400_r == '0);
  assign len   = month_len(m_r, leap);
  assign y_inc = y_r + 1'b1;
  // zeller counts january and february in the previous year
  assign zy    = (m_r < 4'd2) ? (y_r - 1'b1) : y_r;
  assign h     = div_rsp.rem[2:0];

  assign div_state = (state_r == S_M12) || (state_r == S_M100) || (state_r == S_M400) ||
                     (state_r == S_ZDIV) || (state_r == S_WDIV);

  dawu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    div_req.start    = div_state && !pend_r;
    div_req.dividend = y_r;
    div_req.divisor  = DIV_100;
    unique case (state_r)
      S_M12: begin
        div_req.dividend = YEAR_W'(m_r) + YEAR_W'(amt_r);
        div_req.divisor  = DIV_12;
      end
      S_M400: begin
        div_req.divisor  = DIV_400;
      end
      S_ZDIV: begin
        div_req.dividend = zy;
      end
      S_WDIV: begin
        div_req.dividend = YEAR_W'(sum_r);
        div_req.divisor  = DIV_7;
      end
      default: begin
      end
    endcase
  end

  assign pend_nxt  = div_req.start | (pend_r & ~div_rsp.done);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    y_nxt         = y_r;
    amt_nxt       = amt_r;
    ovf_nxt       = ovf_r;
    y100_nxt      = y100_r;
    y400_nxt      = y400_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    sum_nxt       = sum_r;
    wd_nxt        = wd_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    od_nxt        = od_r;
    om_nxt        = om_r;
    oy_nxt        = oy_r;
    owd_nxt       = owd_r;
    oovf_nxt      = oovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          d_nxt     = YEAR_W'((in_day_f == 5'd0) ? 5'd1 : in_day_f);
          m_nxt     = (in_month_f > M_DEC) ? M_DEC : in_month_f;
          y_nxt     = YEAR_W'((in_year_f == 14'd0) ? 14'd1 : in_year_f);
          amt_nxt   = in_tdata[38:23];
          ovf_nxt   = 1'b0;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (y_r > MAX_Y) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_SAT;
        end else begin
          unique case (op_r)
            OP_ADD_DAYS: begin
              d_nxt     = d_r + YEAR_W'(amt_r);
              state_nxt = S_M100;
            end
            OP_ADD_MONTHS: state_nxt = S_M12;
            OP_ADD_YEARS: begin
              y_nxt     = y_r + YEAR_W'(amt_r);
              state_nxt = S_YCHK;
            end
            OP_NONE:       state_nxt = S_M100;
          endcase
        end
      end
      S_M12: begin
        if (div_rsp.done) begin
          m_nxt     = div_rsp.rem[3:0];
          y_nxt     = y_r + div_rsp.quo;
          state_nxt = S_YCHK;
        end
      end
      S_YCHK: begin
        if (y_r > MAX_Y) begin
          ovf_nxt   = 1'b1;
          state_nxt = S_SAT;
        end else begin
          state_nxt = S_M100;
        end
      end
      S_M100: begin
        if (div_rsp.done) begin
          y100_nxt  = div_rsp.rem[Y100_W-1:0];
          state_nxt = S_M400;
        end
      end
      S_M400: begin
        if (div_rsp.done) begin
          y400_nxt  = div_rsp.rem[Y400_W-1:0];
          state_nxt = (op_r == OP_ADD_DAYS) ? S_WALK : S_CLAMP;
        end
      end
      S_WALK: begin
        if (d_r > YEAR_W'(len)) begin
          d_nxt = d_r - YEAR_W'(len);
          if (m_r == M_DEC) begin
            m_nxt = M_JAN;
            if (y_inc > MAX_Y) begin
              ovf_nxt   = 1'b1;
              state_nxt = S_SAT;
            end else begin
              // keep the leap-year residues in step with the year
              y_nxt    = y_inc;
              y100_nxt = (y100_r == Y100_W'(99)) ? '0 : y100_r + 1'b1;
              y400_nxt = (y400_r == Y400_W'(399)) ? '0 : y400_r + 1'b1;
            end
          end else begin
            m_nxt = m_r + 1'b1;
          end
        end else begin
          state_nxt = S_ZDIV;
        end
      end
      S_CLAMP: begin
        if (d_r > YEAR_W'(len)) begin
          d_nxt = YEAR_W'(len);
        end
        state_nxt = S_ZDIV;
      end
      S_SAT: begin
        d_nxt     = YEAR_W'(DEC_DAYS);
        m_nxt     = M_DEC;
        y_nxt     = MAX_Y;
        state_nxt = S_ZDIV;
      end
      S_ZDIV: begin
        if (div_rsp.done) begin
          k_nxt     = div_rsp.rem[Y100_W-1:0];
          j_nxt     = div_rsp.quo[J_W-1:0];
          state_nxt = S_ZSUM;
        end
      end
      S_ZSUM: begin
        sum_nxt = SUM_W'(d_r[4:0]) + SUM_W'(month_off(m_r)) + SUM_W'(k_r) +
                  SUM_W'(k_r >> 2) + SUM_W'(j_r >> 2) + SUM_W'({j_r, 2'b00}) +
                  SUM_W'(j_r);
        state_nxt = S_WDIV;
      end
      S_WDIV: begin
        if (div_rsp.done) begin
          // zeller counts saturday as 0, shift so sunday is 0
          wd_nxt    = (h == 3'd0) ? 3'd6 : h - 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          od_nxt        = d_r[4:0];
          om_nxt        = m_r;
          oy_nxt        = y_r[13:0];
          owd_nxt       = wd_r;
          oovf_nxt      = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    d_r    <= d_nxt;
    m_r    <= m_nxt;
    y_r    <= y_nxt;
    amt_r  <= amt_nxt;
    ovf_r  <= ovf_nxt;
    y100_r <= y100_nxt;
    y400_r <= y400_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    sum_r  <= sum_nxt;
    wd_r   <= wd_nxt;
    od_r   <= od_nxt;
    om_r   <= om_nxt;
    oy_r   <= oy_nxt;
    owd_r  <= owd_nxt;
    oovf_r <= oovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, owd_r, oy_r, om_r, od_r};
  assign out_tuser  = oovf_r;

endmodule
`default_nettype wire

// ----- design/dawu_chk.sv -----
// port-level checks for the date adder, bound to the top level
`default_nettype none
module dawu_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [0:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // one item at a time: busy after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // saturated results are 31 december
  a_sat_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[4:0] == 5'd31 && out_tdata[8:5] == 4'd11)
    else $error("saturated date is not 31 december");

  // result fields stay in range
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] != 5'd0 && out_tdata[8:5] <= 4'd11 &&
                   out_tdata[25:23] <= 3'd6 && out_tdata[31:26] == 6'd0)
    else $error("result field out of range");

endmodule

bind date_add_and_weekday_unit dawu_chk u_dawu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
